// ===== src/lru_key_value_cache_assert.svh =====
// Assertion macros shared by the LRU key-value cache RTL.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LKVC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/lkvc_pkg.sv =====
// Shared types and constants of the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    localparam logic FUNC_GET = 1'b0;
    localparam logic FUNC_PUT = 1'b1;

    localparam logic [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] PUT_VALUE  = 32'h0000_0000;
    localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_RESP   = 4'b1000
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic update;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

// ===== src/lkvc_ctrl.sv =====
// Controller state machine of the LRU key-value cache.
`timescale 1ns / 1ps
module lkvc_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  lkvc_pkg::status_t status,
    output lkvc_pkg::cmd_t    cmd
);
    import lkvc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                // Nothing is taken while reset is held.
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_done) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // The result waits here until the output register is free.
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lkvc_dp.sv =====
// Datapath of the LRU key-value cache: tag and value memories, valid and rank registers.
`timescale 1ns / 1ps
module lkvc_dp #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]  cfg_data,
    input  logic                        in_func,
    input  logic [lkvc_pkg::DATA_W-1:0] in_key,
    input  logic [lkvc_pkg::DATA_W-1:0] in_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_found,
    output logic [lkvc_pkg::DATA_W-1:0] out_value,
    input  lkvc_pkg::cmd_t              cmd,
    output lkvc_pkg::status_t           status
);
    import lkvc_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    // Held item.
    logic              func_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] wval_reg;

    logic [CAP_W-1:0]  cap_reg;

    // Store.
    logic [DATA_W-1:0]      key_mem [MAX_ENTRIES];
    logic [DATA_W-1:0]      val_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [MAX_ENTRIES-1:0] valid_next;
    logic [IDX_W-1:0]       rank_reg  [MAX_ENTRIES];
    logic [IDX_W-1:0]       rank_next [MAX_ENTRIES];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    // Scan state.
    logic [CNT_W-1:0]  scan_cnt_reg;
    logic [IDX_W-1:0]  scan_idx;
    logic              issue;
    logic              rd_vld_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [DATA_W-1:0] key_rd_reg;
    logic [DATA_W-1:0] val_rd_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [IDX_W-1:0]  hit_rank_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [IDX_W-1:0]  vic_idx_reg;
    logic [IDX_W-1:0]  last_rank;

    // Update decisions.
    logic [CMP_W-1:0]  cap_ext;
    logic [CMP_W-1:0]  eff_cap;
    logic              evict;
    logic [IDX_W-1:0]  ins_idx;
    logic [IDX_W-1:0]  wr_idx;

    logic              out_valid_reg;
    logic              out_found_reg;
    logic [DATA_W-1:0] out_value_reg;

    assign scan_idx  = scan_cnt_reg[IDX_W-1:0];
    assign issue     = cmd.scan && (scan_cnt_reg != MAX_CNT);
    assign last_rank = IDX_W'(count_reg - 1'b1);

    assign status.scan_done = (scan_cnt_reg == MAX_CNT);
    assign status.out_free  = !out_valid_reg || out_ready;

    // A capacity of zero acts as one; anything above the store size saturates.
    assign cap_ext = CMP_W'(cap_reg);
    always_comb begin
        priority if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign evict = (CMP_W'(count_reg) >= eff_cap);

    // The new key goes to the lowest free slot once the victim has been dropped.
    assign ins_idx = (evict && (!free_reg || (vic_idx_reg < free_idx_reg))) ?
                     vic_idx_reg : free_idx_reg;
    assign wr_idx  = hit_reg ? hit_idx_reg : ins_idx;

    always_comb begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        if (cmd.update) begin
            if (hit_reg) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (valid_reg[i] && (rank_reg[i] < hit_rank_reg)) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                rank_next[hit_idx_reg] = '0;
            end else if (func_reg == FUNC_PUT) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (evict && (IDX_W'(i) == vic_idx_reg)) begin
                        valid_next[i] = 1'b0;
                        rank_next[i]  = '0;
                    end else if (valid_reg[i]) begin
                        rank_next[i] = rank_reg[i] + 1'b1;
                    end
                end
                valid_next[ins_idx] = 1'b1;
                rank_next[ins_idx]  = '0;
                if (!evict) begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_data;
            end
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            count_reg <= count_next;
            rd_vld_reg <= issue;
            if (cmd.load) begin
                scan_cnt_reg <= '0;
                hit_reg      <= 1'b0;
                free_reg     <= 1'b0;
            end else if (issue) begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
            if (issue && !valid_reg[scan_idx] && !free_reg) begin
                free_reg <= 1'b1;
            end
            if (rd_vld_reg && !hit_reg && valid_reg[rd_idx_reg] && (key_rd_reg == key_reg)) begin
                hit_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and memories.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= in_func;
            key_reg  <= in_key;
            wval_reg <= in_value;
        end
        if (issue) begin
            key_rd_reg <= key_mem[scan_idx];
            rd_idx_reg <= scan_idx;
            if (!valid_reg[scan_idx] && !free_reg) begin
                free_idx_reg <= scan_idx;
            end
            // Ranks are unique, so the least recent entry holds rank count-1.
            if (valid_reg[scan_idx] && (rank_reg[scan_idx] == last_rank)) begin
                vic_idx_reg <= scan_idx;
            end
        end
        if (rd_vld_reg && !hit_reg && valid_reg[rd_idx_reg] && (key_rd_reg == key_reg)) begin
            hit_idx_reg  <= rd_idx_reg;
            hit_rank_reg <= rank_reg[rd_idx_reg];
        end
        if (cmd.update) begin
            val_rd_reg <= val_mem[hit_idx_reg];
            if (func_reg == FUNC_PUT) begin
                val_mem[wr_idx] <= wval_reg;
                if (!hit_reg) begin
                    key_mem[ins_idx] <= key_reg;
                end
            end
        end
        if (cmd.out_load) begin
            out_found_reg <= hit_reg;
            if (func_reg == FUNC_PUT) begin
                out_value_reg <= PUT_VALUE;
            end else if (hit_reg) begin
                out_value_reg <= val_rd_reg;
            end else begin
                out_value_reg <= MISS_VALUE;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_found = out_found_reg;
    assign out_value = out_value_reg;

endmodule

// ===== src/lru_key_value_cache.sv =====
// Top level of the LRU key-value cache: controller, datapath and checks.
//
// Usage: the s_ channel carries one get or put per transfer. s_tuser[0] is
// the operation (0 get, 1 put), s_tdata[31:0] the key and s_tdata[63:32] the
// value stored by a put. Every transfer yields exactly one m_ transfer:
// m_tuser[0] says whether the key was present, m_tdata holds the stored value
// on a get hit, all ones on a get miss and zero for a put.
// The cfg_ channel writes the capacity (1 to MAX_ENTRIES, zero acts as one).
// Timing: one item at a time. The key memory is read one entry per cycle, so
// the lookup scan covers all MAX_ENTRIES slots; it is followed by an update
// step and by loading the output register. s_tready is high only while the
// block is idle.
// Reset empties the store and sets the capacity to 16; there is no clearing
// pass, and neither s_tready nor cfg_ready is high while reset is held.
// When the receiver stalls, the result stays in the output register and
// the next item is still taken and processed; its result waits in the
// controller until the output register frees up.
`timescale 1ns / 1ps
`include "lru_key_value_cache_assert.svh"
module lru_key_value_cache #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,    // capacity_in_use
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [31:0] key, [63:32] write_value
    input  logic [0:0]  s_tuser,     // [0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] read_value
    output logic [0:0]  m_tuser      // [0] found
);
    import lkvc_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = aresetn;

    lkvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lkvc_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_func   (s_tuser[0]),
        .in_key    (s_tdata[31:0]),
        .in_value  (s_tdata[63:32]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_found (m_tuser[0]),
        .out_value (m_tdata),
        .cmd       (cmd),
        .status    (status)
    );

    `LKVC_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "input accepted while an item is in flight")
    `LKVC_ASSERT_NOW(a_load_into_free_slot, aclk, aresetn, cmd.out_load, status.out_free,
        "result loaded over a pending output")
    `LKVC_ASSERT_NEXT(a_update_after_scan, aclk, aresetn, cmd.scan && status.scan_done,
        cmd.update, "scan end not followed by update")

endmodule
